### design/tncc_pkg.sv
// shared constants and types for the triangle normal, centroid and cull unit
package tncc_pkg;

    localparam int COORD_WIDTH_DEF = 20;
    localparam int NORM_W          = 43;
    localparam int CENTER_W        = 20;
    localparam int CFG_W           = 14;
    localparam int FRAC_BITS       = 4;
    localparam int SCR_W           = CFG_W + FRAC_BITS;
    localparam int CFG_ADDR_W      = 1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

endpackage

### design/tncc_if.sv
// request channels: triangle vertices in, setup results out
interface tncc_vtx_if #(
    parameter int COORD_WIDTH = tncc_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] v1_x;
    logic signed [COORD_WIDTH-1:0] v1_y;
    logic signed [COORD_WIDTH-1:0] v1_z;
    logic signed [COORD_WIDTH-1:0] v2_x;
    logic signed [COORD_WIDTH-1:0] v2_y;
    logic signed [COORD_WIDTH-1:0] v2_z;
    logic signed [COORD_WIDTH-1:0] v3_x;
    logic signed [COORD_WIDTH-1:0] v3_y;
    logic signed [COORD_WIDTH-1:0] v3_z;

    modport source (output valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
                    input ready);
    modport sink   (input valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
                    output ready);
endinterface

interface tncc_res_if;
    import tncc_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [NORM_W-1:0]   normal_x;
    logic signed [NORM_W-1:0]   normal_y;
    logic signed [NORM_W-1:0]   normal_z;
    logic signed [CENTER_W-1:0] center_x;
    logic signed [CENTER_W-1:0] center_y;
    logic signed [CENTER_W-1:0] center_z;
    logic                       off_screen;
    logic                       visible;

    modport source (output valid, normal_x, normal_y, normal_z, center_x, center_y, center_z,
                    off_screen, visible, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, center_x, center_y, center_z,
                    off_screen, visible, output ready);
endinterface

### design/triangle_normal_centroid_cull_unit.sv
// top level: triangle setup pipeline with normal, centroid and backface cull
//
// Takes one triangle per clock while the result side accepts, and gives one result per triangle, in order.
// The work runs through a seven-stage pipeline; when the output side is
// not stalled, throughput is one triangle per cycle. Every stage holds a
// valid bit and advances when it is empty or the stage after it advances,
// so a stall on the result side fills bubbles first and only then lowers
// vtx.ready. The stages are: edge vectors, vertex sums and screen reject
// tests; the six cross products and the centroid reciprocal multiply;
// normal subtract and divide-by-3 correction; camera vector clamp; the
// split normal-times-camera partial products; partial sums; final dot
// product sign and output register.
// Screen width and height are written through cfg_we/cfg_index/cfg_wdata and
// must only change while no triangle is in flight.
module triangle_normal_centroid_cull_unit #(
    parameter int COORD_WIDTH = tncc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tncc_pkg::CFG_ADDR_W-1:0]      cfg_index,
    input  logic [tncc_pkg::CFG_W-1:0]           cfg_wdata,
    tncc_vtx_if.sink                             vtx,
    tncc_res_if.source                           res
);
    import tncc_pkg::*;

    // widths
    localparam int CW    = COORD_WIDTH;
    localparam int EW    = CW + 1;                         // edge vector
    localparam int SW    = CW + 2;                         // sum of three vertices
    localparam int MW    = CW + 1;                         // sum magnitude
    localparam int K     = MW + 1;                         // reciprocal shift
    localparam int PW    = (2 * EW > NORM_W) ? 2 * EW : NORM_W;
    localparam int OW    = ((CW > SCR_W) ? CW : SCR_W) + 1; // screen compare
    localparam int CAM_W = ((CW > SCR_W) ? CW : SCR_W) + 2; // camera vector
    localparam int LO_W  = 22;                             // low normal slice
    localparam int HI_W  = NORM_W - LO_W;
    localparam int PLO_W = LO_W + 1 + CAM_W;
    localparam int PHI_W = HI_W + CAM_W;
    localparam int SLO_W = PLO_W + 2;
    localparam int SHI_W = PHI_W + 2;
    localparam int TW    = ((SHI_W + LO_W > SLO_W) ? SHI_W + LO_W : SLO_W) + 1;
    localparam int CXW   = (CW > CENTER_W) ? CW : CENTER_W;
    localparam int NSTG  = 7;

    // floor(2^K / 3): centroid magnitude times this, shifted by K, is low by at most one
    localparam logic [MW-1:0] RECIP3 = MW'((64'd1 << K) / 3);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_wdata;
                CFG_SCREEN_HEIGHT: height_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // bounds in the 4-fraction-bit coordinate format
    logic signed [OW-1:0] wb_s;
    logic signed [OW-1:0] hb_s;
    assign wb_s = signed'(OW'({width_reg, {FRAC_BITS{1'b0}}}));
    assign hb_s = signed'(OW'({height_reg, {FRAC_BITS{1'b0}}}));

    // ------------------------------------------------------------------
    // pipeline flow control
    // ------------------------------------------------------------------
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] adv;

    always_comb
    begin
        adv[NSTG-1] = !v_reg[NSTG-1] || res.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign vtx.ready = adv[0];
    assign res.valid = v_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= vtx.valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // signed product, sign-extended or cut to the normal width
    function automatic logic [NORM_W-1:0] mul_n(input logic signed [EW-1:0] a,
                                                input logic signed [EW-1:0] b);
        logic signed [2*EW-1:0] p;
        logic signed [PW-1:0]   pe;
        p  = a * b;
        pe = PW'(p);
        return pe[NORM_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // stage 0: edges, vertex sums, off-screen test
    // ------------------------------------------------------------------
    logic signed [CW-1:0] va [0:2];
    logic signed [CW-1:0] vb [0:2];
    logic signed [CW-1:0] vc [0:2];

    assign va[0] = vtx.v1_x;
    assign va[1] = vtx.v1_y;
    assign va[2] = vtx.v1_z;
    assign vb[0] = vtx.v2_x;
    assign vb[1] = vtx.v2_y;
    assign vb[2] = vtx.v2_z;
    assign vc[0] = vtx.v3_x;
    assign vc[1] = vtx.v3_y;
    assign vc[2] = vtx.v3_z;

    logic signed [EW-1:0] e12_next [0:2];
    logic signed [EW-1:0] e23_next [0:2];
    logic signed [SW-1:0] sum_next [0:2];
    logic                 off0_next;
    logic signed [EW-1:0] e12_reg  [0:2];
    logic signed [EW-1:0] e23_reg  [0:2];
    logic signed [SW-1:0] sum_reg  [0:2];
    logic                 off0_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            e12_next[j] = EW'(vb[j]) - EW'(va[j]);
            e23_next[j] = EW'(vc[j]) - EW'(vb[j]);
            sum_next[j] = SW'(va[j]) + SW'(vb[j]) + SW'(vc[j]);
        end
        // all three beyond one screen edge
        off0_next = (va[0][CW-1] && vb[0][CW-1] && vc[0][CW-1])
                 || (va[1][CW-1] && vb[1][CW-1] && vc[1][CW-1])
                 || ((OW'(va[0]) >= wb_s) && (OW'(vb[0]) >= wb_s) && (OW'(vc[0]) >= wb_s))
                 || ((OW'(va[1]) >= hb_s) && (OW'(vb[1]) >= hb_s) && (OW'(vc[1]) >= hb_s));
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            e12_reg  <= e12_next;
            e23_reg  <= e23_next;
            sum_reg  <= sum_next;
            off0_reg <= off0_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: cross products, centroid reciprocal multiply
    // ------------------------------------------------------------------
    logic [NORM_W-1:0] pa_next   [0:2];
    logic [NORM_W-1:0] pb_next   [0:2];
    logic [MW-1:0]     mag_next  [0:2];
    logic [2*MW-1:0]   cp_next   [0:2];
    logic [NORM_W-1:0] pa_reg    [0:2];
    logic [NORM_W-1:0] pb_reg    [0:2];
    logic [MW-1:0]     mag_reg   [0:2];
    logic [2*MW-1:0]   cp_reg    [0:2];
    logic [2:0]        neg1_reg;
    logic              off1_reg;

    always_comb
    begin
        pa_next[0] = mul_n(e23_reg[1], e12_reg[2]);
        pb_next[0] = mul_n(e23_reg[2], e12_reg[1]);
        pa_next[1] = mul_n(e23_reg[2], e12_reg[0]);
        pb_next[1] = mul_n(e23_reg[0], e12_reg[2]);
        pa_next[2] = mul_n(e23_reg[0], e12_reg[1]);
        pb_next[2] = mul_n(e23_reg[1], e12_reg[0]);
        for (int j = 0; j < 3; j++)
        begin
            mag_next[j] = sum_reg[j][SW-1] ? MW'(-sum_reg[j]) : MW'(sum_reg[j]);
            cp_next[j]  = (2*MW)'(mag_next[j]) * (2*MW)'(RECIP3);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            mag_reg  <= mag_next;
            cp_reg   <= cp_next;
            neg1_reg <= {sum_reg[2][SW-1], sum_reg[1][SW-1], sum_reg[0][SW-1]};
            off1_reg <= off0_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: normal subtract, divide-by-3 correction
    // ------------------------------------------------------------------
    logic [NORM_W-1:0]    nrm2_next [0:2];
    logic signed [CW-1:0] cen2_next [0:2];
    logic [NORM_W-1:0]    nrm2_reg  [0:2];
    logic signed [CW-1:0] cen2_reg  [0:2];
    logic                 off2_reg;

    always_comb
    begin
        logic [MW-2:0] qe;
        logic [MW-1:0] rem;
        logic [CW-1:0] q;
        for (int j = 0; j < 3; j++)
        begin
            nrm2_next[j] = pa_reg[j] - pb_reg[j];
            qe  = cp_reg[j][2*MW-1:K];
            rem = mag_reg[j] - MW'({qe, 1'b0}) - MW'(qe);
            q   = CW'(qe) + CW'(rem >= MW'(3));
            // truncate toward zero: divide the magnitude, then restore the sign
            cen2_next[j] = neg1_reg[j] ? signed'(-q) : signed'(q);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            nrm2_reg <= nrm2_next;
            cen2_reg <= cen2_next;
            off2_reg <= off1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: camera vector, x and y centroid clamped to the screen minus centroid, z the centroid
    // ------------------------------------------------------------------
    logic signed [CAM_W-1:0] cam_next [0:2];
    logic signed [CAM_W-1:0] cam_reg  [0:2];
    logic [NORM_W-1:0]       nrm3_reg [0:2];
    logic signed [CW-1:0]    cen3_reg [0:2];
    logic                    off3_reg;

    always_comb
    begin
        logic signed [CAM_W-1:0] cx;
        logic signed [CAM_W-1:0] cy;
        cx = CAM_W'(cen2_reg[0]);
        cy = CAM_W'(cen2_reg[1]);
        if (cx < 0)
            cam_next[0] = -cx;
        else if (cx > CAM_W'(wb_s))
            cam_next[0] = CAM_W'(wb_s) - cx;
        else
            cam_next[0] = '0;
        if (cy < 0)
            cam_next[1] = -cy;
        else if (cy > CAM_W'(hb_s))
            cam_next[1] = CAM_W'(hb_s) - cy;
        else
            cam_next[1] = '0;
        cam_next[2] = CAM_W'(cen2_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            cam_reg  <= cam_next;
            nrm3_reg <= nrm2_reg;
            cen3_reg <= cen2_reg;
            off3_reg <= off2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: normal times camera, normal split into low and high slices
    // ------------------------------------------------------------------
    logic signed [PLO_W-1:0] plo_next [0:2];
    logic signed [PHI_W-1:0] phi_next [0:2];
    logic signed [PLO_W-1:0] plo_reg  [0:2];
    logic signed [PHI_W-1:0] phi_reg  [0:2];
    logic [NORM_W-1:0]       nrm4_reg [0:2];
    logic signed [CW-1:0]    cen4_reg [0:2];
    logic                    off4_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            plo_next[j] = PLO_W'(signed'({1'b0, nrm3_reg[j][LO_W-1:0]})) * PLO_W'(cam_reg[j]);
            phi_next[j] = PHI_W'(signed'(nrm3_reg[j][NORM_W-1:LO_W])) * PHI_W'(cam_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            nrm4_reg <= nrm3_reg;
            cen4_reg <= cen3_reg;
            off4_reg <= off3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: partial sums over the three axes
    // ------------------------------------------------------------------
    logic signed [SLO_W-1:0] slo_reg;
    logic signed [SHI_W-1:0] shi_reg;
    logic [NORM_W-1:0]       nrm5_reg [0:2];
    logic signed [CW-1:0]    cen5_reg [0:2];
    logic                    off5_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            slo_reg  <= SLO_W'(plo_reg[0]) + SLO_W'(plo_reg[1]) + SLO_W'(plo_reg[2]);
            shi_reg  <= SHI_W'(phi_reg[0]) + SHI_W'(phi_reg[1]) + SHI_W'(phi_reg[2]);
            nrm5_reg <= nrm4_reg;
            cen5_reg <= cen4_reg;
            off5_reg <= off4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: dot product sign, output register
    // ------------------------------------------------------------------
    logic signed [TW-1:0]       dot_next;
    logic                       vis_next;
    logic signed [CXW-1:0]      cx_ext [0:2];
    logic [NORM_W-1:0]          nrm_out_reg [0:2];
    logic [CENTER_W-1:0]        cen_out_reg [0:2];
    logic                       off_out_reg;
    logic                       vis_out_reg;

    always_comb
    begin
        dot_next = (TW'(shi_reg) <<< LO_W) + TW'(slo_reg);
        vis_next = !off5_reg && dot_next[TW-1];
        for (int j = 0; j < 3; j++)
        begin
            cx_ext[j] = CXW'(cen5_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            nrm_out_reg <= nrm5_reg;
            for (int j = 0; j < 3; j++)
            begin
                cen_out_reg[j] <= cx_ext[j][CENTER_W-1:0];
            end
            off_out_reg <= off5_reg;
            vis_out_reg <= vis_next;
        end
    end

    assign res.normal_x   = nrm_out_reg[0];
    assign res.normal_y   = nrm_out_reg[1];
    assign res.normal_z   = nrm_out_reg[2];
    assign res.center_x   = cen_out_reg[0];
    assign res.center_y   = cen_out_reg[1];
    assign res.center_z   = cen_out_reg[2];
    assign res.off_screen = off_out_reg;
    assign res.visible    = vis_out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a rejected triangle is never reported visible
    a_off_not_visible: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.off_screen && res.visible))
        else $error("off-screen triangle flagged visible");

    // a degenerate triangle has a zero dot product and cannot be visible
    a_zero_normal: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.normal_x == '0 && res.normal_y == '0 && res.normal_z == '0)
        |-> !res.visible)
        else $error("zero normal flagged visible");

    // with the output side free, the pipeline always takes a new request
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        res.ready |-> vtx.ready)
        else $error("input stalled while output side is ready");

    // a held first stage keeps its item
    a_first_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[0] && !adv[0]) |=> v_reg[0])
        else $error("first stage dropped an item");

    // an accepted request leaves the first stage occupied
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (vtx.valid && vtx.ready) |=> v_reg[0])
        else $error("accepted request not captured");

endmodule
